// ===== rtl/dual_sensor_pd_line_follower_core_assert.svh =====
// Assertion macros shared by the line follower checker.
`ifndef DUAL_SENSOR_PD_LINE_FOLLOWER_CORE_ASSERT_SVH
`define DUAL_SENSOR_PD_LINE_FOLLOWER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSPD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line follower assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DSPD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line follower assertion failed");

`endif

// ===== rtl/dspd_pkg.sv =====
// Types and constants shared by the line follower core and its divider.
`timescale 1ns / 1ps

package dspd_pkg;

    localparam int DATA_W  = 10;
    localparam int GAIN_W  = 6;
    localparam int BASE_W  = 7;
    localparam int POWER_W = 13;
    localparam int DVD_W   = 25;
    localparam int MAG_W   = 24;
    localparam int DVS_W   = 11;
    localparam int CNT_W   = 5;
    localparam int TURN_W  = 26;
    localparam int PG_W    = 13;
    localparam int RANGE_SCALE = 100;

    localparam logic [CNT_W-1:0]       LAST_STEP  = CNT_W'(MAG_W - 1);
    localparam logic [DATA_W-1:0]      FULL_SCALE = 10'd1023;
    localparam logic signed [DVS_W-1:0] BAND_HI   = 11'sd50;
    localparam logic signed [DVS_W-1:0] BAND_LO   = -11'sd50;
    localparam logic signed [TURN_W-1:0] POWER_MAX = 26'sd8191;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] GAIN_P_LOW_RST  = 6'd2;
    localparam logic [GAIN_W-1:0] GAIN_P_HIGH_RST = 6'd5;
    localparam logic [GAIN_W-1:0] GAIN_D_RST      = 6'd3;
    localparam logic [BASE_W-1:0] BASE_POWER_RST  = 7'd50;
    localparam logic [DATA_W-1:0] CAL_LOW_RST     = 10'd0;
    localparam logic [DATA_W-1:0] CAL_HIGH_RST    = 10'd1023;

    typedef enum logic [2:0] {
        CFG_GAIN_P_LOW     = 3'd0,
        CFG_GAIN_P_HIGH    = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_BASE_POWER     = 3'd3,
        CFG_LIGHT_CAL_LOW  = 3'd4,
        CFG_LIGHT_CAL_HIGH = 3'd5,
        CFG_COLOR_CAL_LOW  = 3'd6,
        CFG_COLOR_CAL_HIGH = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MULP,
        ST_DSTART,
        ST_DWAIT,
        ST_MULD,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DVD_W-1:0]  dividend;
        logic signed [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DVD_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== rtl/dspd_div.sv =====
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module dspd_div import dspd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0]       rem_reg, rem_next;
    logic [MAG_W-1:0]        quo_reg, quo_next;
    logic [DATA_W-1:0]       dvs_reg, dvs_next;
    logic                    neg_reg, neg_next;
    logic signed [DVD_W-1:0] q_reg, q_next;

    logic signed [DVD_W-1:0] a_abs;
    logic signed [DVS_W-1:0] b_abs;
    logic [DATA_W:0]         rem_sh;
    logic [DATA_W:0]         rem_diff;
    logic                    fits;
    logic [MAG_W-1:0]        quo_step;
    logic signed [DVD_W-1:0] q_pos;

    // Magnitudes of the operands and one restoring step.
    always_comb begin
        a_abs    = req.dividend[DVD_W-1] ? -req.dividend : req.dividend;
        b_abs    = req.divisor[DVS_W-1] ? -req.divisor : req.divisor;
        rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        quo_step = {quo_reg[MAG_W-2:0], fits};
        q_pos    = $signed({1'b0, quo_step});
    end

    // Next values: load on start, then step until the last quotient bit.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = a_abs[MAG_W-1:0];
            dvs_next  = b_abs[DATA_W-1:0];
            neg_next  = req.dividend[DVD_W-1] ^ req.divisor[DVS_W-1];
        end else if (busy_reg) begin
            rem_next = fits ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_next = quo_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = neg_reg ? -q_pos : q_pos;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== rtl/dual_sensor_pd_line_follower_core.sv =====
// Two-sensor PD line follower core: range tracking, PD turn and motor powers.
// A channel whose range is zero skips its multiplies and divisions and goes straight
// from PREP to SUM, so a word makes up to four divisions that share one radix-2
// divider; s_tready is high only while the sequencer is idle, so a new word is taken
// only after the previous result has moved into the output register.
// Reset (aresetn low, synchronous) loads register defaults and calibration
// bounds, clears the previous samples and drops m_tvalid.
`timescale 1ns / 1ps

module dual_sensor_pd_line_follower_core import dspd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] light_raw, [19:10] color_level, rest zero
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] right_power, [25:13] left_power, rest zero
    output logic [0:0]  m_tuser,   // [0] range_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [GAIN_W-1:0] gain_p_low_reg, gain_p_high_reg, gain_d_reg;
    logic [BASE_W-1:0] base_power_reg;
    logic [DATA_W-1:0] light_cal_low_reg, light_cal_high_reg;
    logic [DATA_W-1:0] color_cal_low_reg, color_cal_high_reg;

    // Tracked state.
    logic [DATA_W-1:0] light_min_reg, light_min_next, light_max_reg, light_max_next;
    logic [DATA_W-1:0] color_min_reg, color_min_next, color_max_reg, color_max_next;
    logic [DATA_W-1:0] light_last_reg, light_last_next, color_last_reg, color_last_next;

    // Per-item working registers.
    logic                     ch_reg, ch_next;
    logic                     phase_reg, phase_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]        lv_reg, lv_next, cv_reg, cv_next;
    logic [DATA_W-1:0]        lp_reg, lp_next, cp_reg, cp_next;
    logic [PG_W-1:0]          pg100_reg, pg100_next;
    logic signed [DVS_W-1:0]  rng_reg, rng_next;
    logic signed [DVS_W:0]    vm_reg, vm_next;
    logic signed [DVD_W-1:0]  numd_reg, numd_next, nump_reg, nump_next;
    logic signed [DVD_W-1:0]  dif_reg, dif_next, pq_reg, pq_next;
    logic signed [TURN_W-1:0] prod_reg, prod_next;
    logic                     zero_reg, zero_next;
    logic                     fault_reg, fault_next;
    logic [POWER_W-1:0]       right_reg, right_next, left_reg, left_next;
    logic [31:0]              m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Input word fields and acceptance-time values.
    logic [DATA_W-1:0]       in_lv, in_cv;
    logic                    in_restart;
    logic [DATA_W-1:0]       lo_l, hi_l, lo_c, hi_c, last_l, last_c;
    logic signed [DVS_W-1:0] ld, cd;
    logic                    in_band;
    logic [GAIN_W-1:0]       pg_sel;

    // Channel datapath values.
    logic [DATA_W-1:0]        v_sel, p_sel, lo_sel, hi_sel;
    logic signed [DVS_W-1:0]  rng_c, rng_adj, half;
    logic signed [DVS_W:0]    mid;
    logic signed [DVS_W-1:0]  dv;
    logic signed [TURN_W-1:0] t_sum, t_adj, t_half, neg_base, t_clip, pw;
    logic [POWER_W-1:0]       pw_sat;
    logic                     out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Restart selection, sample changes and gain selection for an arriving word.
    always_comb begin
        in_lv      = FULL_SCALE - s_tdata[9:0];
        in_cv      = s_tdata[19:10];
        in_restart = s_tuser[0];
        lo_l       = in_restart ? light_cal_low_reg : light_min_reg;
        hi_l       = in_restart ? light_cal_high_reg : light_max_reg;
        lo_c       = in_restart ? color_cal_low_reg : color_min_reg;
        hi_c       = in_restart ? color_cal_high_reg : color_max_reg;
        last_l     = in_restart ? '0 : light_last_reg;
        last_c     = in_restart ? '0 : color_last_reg;
        ld         = $signed({1'b0, in_lv}) - $signed({1'b0, last_l});
        cd         = $signed({1'b0, in_cv}) - $signed({1'b0, last_c});
        in_band    = (ld < BAND_HI) && (ld > BAND_LO) && (cd < BAND_HI) && (cd > BAND_LO);
        pg_sel     = in_band ? gain_p_low_reg : gain_p_high_reg;
    end

    // Range, midpoint and sample change of the current channel.
    always_comb begin
        v_sel   = ch_reg ? cv_reg : lv_reg;
        p_sel   = ch_reg ? cp_reg : lp_reg;
        lo_sel  = ch_reg ? color_min_reg : light_min_reg;
        hi_sel  = ch_reg ? color_max_reg : light_max_reg;
        rng_c   = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
        rng_adj = rng_c + $signed({{(DVS_W-1){1'b0}}, rng_c[DVS_W-1]});
        half    = rng_adj >>> 1;
        mid     = $signed({2'b00, lo_sel}) + $signed({half[DVS_W-1], half});
        dv      = $signed({1'b0, v_sel}) - $signed({1'b0, p_sel});
    end

    // Turn: sum, halve toward zero, clamp at minus base power, add base power, saturate at the power maximum.
    always_comb begin
        t_sum    = zero_reg ? '0 : (TURN_W'(pq_reg) + prod_reg);
        t_adj    = t_sum + $signed({{(TURN_W-1){1'b0}}, t_sum[TURN_W-1]});
        t_half   = t_adj >>> 1;
        neg_base = -$signed({{(TURN_W-BASE_W){1'b0}}, base_power_reg});
        t_clip   = (t_half < neg_base) ? neg_base : t_half;
        pw       = $signed({{(TURN_W-BASE_W){1'b0}}, base_power_reg}) + t_clip;
        pw_sat   = (pw > POWER_MAX) ? POWER_MAX[POWER_W-1:0] : pw[POWER_W-1:0];
        out_load = !m_tvalid_reg || m_tready;
    end

    // Shared divider request.
    always_comb begin
        div_req.start    = (state_reg == ST_DSTART);
        div_req.dividend = phase_reg ? nump_reg : numd_reg;
        div_req.divisor  = rng_reg;
    end

    dspd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_PREP;
            ST_PREP:   state_next = (rng_c == '0) ? ST_SUM : ST_MULP;
            ST_MULP:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done) state_next = phase_reg ? ST_MULD : ST_DSTART;
            end
            ST_MULD:   state_next = ST_SUM;
            ST_SUM:    state_next = ch_reg ? ST_OUT : ST_PREP;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register next values.
    always_comb begin
        light_min_next  = light_min_reg;
        light_max_next  = light_max_reg;
        color_min_next  = color_min_reg;
        color_max_next  = color_max_reg;
        light_last_next = light_last_reg;
        color_last_next = color_last_reg;
        ch_next         = ch_reg;
        phase_next      = phase_reg;
        lv_next         = lv_reg;
        cv_next         = cv_reg;
        lp_next         = lp_reg;
        cp_next         = cp_reg;
        pg100_next      = pg100_reg;
        rng_next        = rng_reg;
        vm_next         = vm_reg;
        numd_next       = numd_reg;
        nump_next       = nump_reg;
        dif_next        = dif_reg;
        pq_next         = pq_reg;
        prod_next       = prod_reg;
        zero_next       = zero_reg;
        fault_next      = fault_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // Below-min is tested first, above-max only otherwise.
                    light_min_next = lo_l;
                    light_max_next = hi_l;
                    if (in_lv < lo_l) light_min_next = in_lv;
                    else if (in_lv > hi_l) light_max_next = in_lv;
                    color_min_next = lo_c;
                    color_max_next = hi_c;
                    if (in_cv < lo_c) color_min_next = in_cv;
                    else if (in_cv > hi_c) color_max_next = in_cv;
                    light_last_next = in_lv;
                    color_last_next = in_cv;
                    lv_next    = in_lv;
                    cv_next    = in_cv;
                    lp_next    = last_l;
                    cp_next    = last_c;
                    pg100_next = PG_W'(pg_sel) * PG_W'(RANGE_SCALE);
                    ch_next    = 1'b0;
                    fault_next = 1'b0;
                end
            end
            ST_PREP: begin
                rng_next   = rng_c;
                vm_next    = $signed({2'b00, v_sel}) - mid;
                numd_next  = DVD_W'(dv) * DVD_W'(RANGE_SCALE);
                zero_next  = (rng_c == '0);
                fault_next = fault_reg || (rng_c == '0);
                phase_next = 1'b0;
            end
            ST_MULP: begin
                nump_next = DVD_W'($signed({1'b0, pg100_reg})) * DVD_W'(vm_reg);
            end
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    if (phase_reg) begin
                        pq_next = div_rsp.quotient;
                    end else begin
                        dif_next   = div_rsp.quotient;
                        phase_next = 1'b1;
                    end
                end
            end
            ST_MULD: begin
                prod_next = TURN_W'($signed({1'b0, gain_d_reg})) * TURN_W'(dif_reg);
            end
            ST_SUM: begin
                if (ch_reg) left_next = pw_sat;
                else right_next = pw_sat;
                ch_next = 1'b1;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tdata_next  = {6'd0, left_reg, right_reg};
                    m_tuser_next  = fault_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_low_reg     <= GAIN_P_LOW_RST;
            gain_p_high_reg    <= GAIN_P_HIGH_RST;
            gain_d_reg         <= GAIN_D_RST;
            base_power_reg     <= BASE_POWER_RST;
            light_cal_low_reg  <= CAL_LOW_RST;
            light_cal_high_reg <= CAL_HIGH_RST;
            color_cal_low_reg  <= CAL_LOW_RST;
            color_cal_high_reg <= CAL_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN_P_LOW:     gain_p_low_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_P_HIGH:    gain_p_high_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                CFG_BASE_POWER:     base_power_reg     <= cfg_data[BASE_W-1:0];
                CFG_LIGHT_CAL_LOW:  light_cal_low_reg  <= cfg_data;
                CFG_LIGHT_CAL_HIGH: light_cal_high_reg <= cfg_data;
                CFG_COLOR_CAL_LOW:  color_cal_low_reg  <= cfg_data;
                CFG_COLOR_CAL_HIGH: color_cal_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control and tracked state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ch_reg         <= 1'b0;
            phase_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            light_min_reg  <= CAL_LOW_RST;
            light_max_reg  <= CAL_HIGH_RST;
            color_min_reg  <= CAL_LOW_RST;
            color_max_reg  <= CAL_HIGH_RST;
            light_last_reg <= '0;
            color_last_reg <= '0;
        end else begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            phase_reg      <= phase_next;
            m_tvalid_reg   <= m_tvalid_next;
            light_min_reg  <= light_min_next;
            light_max_reg  <= light_max_next;
            color_min_reg  <= color_min_next;
            color_max_reg  <= color_max_next;
            light_last_reg <= light_last_next;
            color_last_reg <= color_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        lv_reg      <= lv_next;
        cv_reg      <= cv_next;
        lp_reg      <= lp_next;
        cp_reg      <= cp_next;
        pg100_reg   <= pg100_next;
        rng_reg     <= rng_next;
        vm_reg      <= vm_next;
        numd_reg    <= numd_next;
        nump_reg    <= nump_next;
        dif_reg     <= dif_next;
        pq_reg      <= pq_next;
        prod_reg    <= prod_next;
        zero_reg    <= zero_next;
        fault_reg   <= fault_next;
        right_reg   <= right_next;
        left_reg    <= left_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// ===== rtl/dspd_checker.sv =====
// Port-level checker for the line follower core and its bind statement.
`timescale 1ns / 1ps
`include "dual_sensor_pd_line_follower_core_assert.svh"

module dspd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // The core is busy right after it takes a word.
    `DSPD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // No result can appear in the cycle after a word is taken.
    `DSPD_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))

    // A fresh result coincides with the core being free for the next word.
    `DSPD_ASSERT_NOW(a_idle_with_result, aclk, aresetn, $rose(m_tvalid), s_tready)

    // A stalled result word holds.
    `DSPD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind dual_sensor_pd_line_follower_core dspd_checker u_dspd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/dual_sensor_pd_line_follower_core_check.sv =====
// Checker for the line follower core: predicts motor powers and compares result words.
`timescale 1ns / 1ps

module dual_sensor_pd_line_follower_core_check import dspd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] light_raw, [19:10] color_level, rest zero
    input  logic [0:0]  s_tuser,   // [0] restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [12:0] right_power, [25:13] left_power, rest zero
    input  logic [0:0]  m_tuser,   // [0] range_fault
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output int          error_count,
    output int          outstanding
);

    typedef struct packed {
        logic [POWER_W-1:0] right_power;
        logic [POWER_W-1:0] left_power;
        logic               range_fault;
    } motor_word_t;

    // Shadow copy of the configuration registers.
    logic [GAIN_W-1:0] p_low_gain, p_high_gain, d_gain;
    logic [BASE_W-1:0] base_pwr;
    logic [DATA_W-1:0] light_lo_cal, light_hi_cal, color_lo_cal, color_hi_cal;

    // Shadow copy of the tracked ranges and previous samples.
    logic [DATA_W-1:0] light_lo, light_hi, color_lo, color_hi;
    logic [DATA_W-1:0] light_prev, color_prev;

    // Motor words still owed by the block, oldest first.
    motor_word_t power_queue[$];

    initial error_count = 0;
    initial outstanding = 0;

    task automatic report_fault(input string msg);
        $display("%0t ns: line follower check: %s", $time, msg);
        error_count++;
    endtask

    // A sample below the range moves the low bound; only otherwise can it move the high bound.
    function automatic void stretch_range(input int v, inout logic [DATA_W-1:0] lo,
                                          inout logic [DATA_W-1:0] hi);
        if (v < int'(lo)) begin
            lo = v[DATA_W-1:0];
        end else if (v > int'(hi)) begin
            hi = v[DATA_W-1:0];
        end
    endfunction

    // PD turn of one channel; a zero span gives no turn and flags the fault.
    function automatic int channel_turn(input int v, input int prev, input int lo,
                                        input int hi, input int pg,
                                        output bit zero_span);
        int span;
        int mid;
        int rate;
        int t;
        span = hi - lo;
        zero_span = (span == 0);
        if (span == 0) begin
            return 0;
        end
        mid  = lo + span / 2;
        rate = (RANGE_SCALE * (v - prev)) / span;
        t    = (pg * RANGE_SCALE * (v - mid)) / span + int'(d_gain) * rate;
        t    = t / 2;
        if (t < -int'(base_pwr)) begin
            t = -int'(base_pwr);
        end
        return t;
    endfunction

    function automatic logic [POWER_W-1:0] motor_power(input int turn);
        int p;
        p = int'(base_pwr) + turn;
        if (p < 0) begin
            p = 0;
        end
        if (p > int'(POWER_MAX)) begin
            p = int'(POWER_MAX);
        end
        return p[POWER_W-1:0];
    endfunction

    function automatic void reload_bounds();
        light_lo   = light_lo_cal;
        light_hi   = light_hi_cal;
        color_lo   = color_lo_cal;
        color_hi   = color_hi_cal;
        light_prev = '0;
        color_prev = '0;
    endfunction

    // Advances the shadow state by one control tick and returns the motor word it yields.
    function automatic motor_word_t predict_powers(input logic [DATA_W-1:0] light_raw,
                                                   input logic [DATA_W-1:0] color_level,
                                                   input logic restart);
        int          lv, cv, ld, cd, pg, lt, ct;
        bit          light_zero, color_zero;
        motor_word_t w;
        lv = int'(FULL_SCALE) - int'(light_raw);
        cv = int'(color_level);
        if (restart) begin
            reload_bounds();
        end
        stretch_range(lv, light_lo, light_hi);
        stretch_range(cv, color_lo, color_hi);

        // Low gain only when both samples moved less than the straight band.
        ld = lv - int'(light_prev);
        cd = cv - int'(color_prev);
        pg = int'(p_high_gain);
        if (ld < int'(BAND_HI) && ld > int'(BAND_LO) && cd < int'(BAND_HI) && cd > int'(BAND_LO)) begin
            pg = int'(p_low_gain);
        end

        lt = channel_turn(lv, int'(light_prev), int'(light_lo), int'(light_hi), pg, light_zero);
        ct = channel_turn(cv, int'(color_prev), int'(color_lo), int'(color_hi), pg, color_zero);
        light_prev = lv[DATA_W-1:0];
        color_prev = cv[DATA_W-1:0];

        w.right_power = motor_power(lt);
        w.left_power  = motor_power(ct);
        w.range_fault = light_zero || color_zero;
        return w;
    endfunction

    function automatic void write_register(input cfg_index_t idx, input logic [9:0] val);
        case (idx)
            CFG_GAIN_P_LOW:     p_low_gain   = val[GAIN_W-1:0];
            CFG_GAIN_P_HIGH:    p_high_gain  = val[GAIN_W-1:0];
            CFG_GAIN_D:         d_gain       = val[GAIN_W-1:0];
            CFG_BASE_POWER:     base_pwr     = val[BASE_W-1:0];
            CFG_LIGHT_CAL_LOW:  light_lo_cal = val[DATA_W-1:0];
            CFG_LIGHT_CAL_HIGH: light_hi_cal = val[DATA_W-1:0];
            CFG_COLOR_CAL_LOW:  color_lo_cal = val[DATA_W-1:0];
            CFG_COLOR_CAL_HIGH: color_hi_cal = val[DATA_W-1:0];
            default: ;
        endcase
    endfunction

    // Track every handshake at the clock edge and compare each result word as it leaves.
    always @(posedge aclk) begin : track
        motor_word_t want;
        if (!aresetn) begin
            p_low_gain   = GAIN_P_LOW_RST;
            p_high_gain  = GAIN_P_HIGH_RST;
            d_gain       = GAIN_D_RST;
            base_pwr     = BASE_POWER_RST;
            light_lo_cal = CAL_LOW_RST;
            light_hi_cal = CAL_HIGH_RST;
            color_lo_cal = CAL_LOW_RST;
            color_hi_cal = CAL_HIGH_RST;
            reload_bounds();
            power_queue.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                write_register(cfg_index_t'(cfg_index), cfg_data);
            end
            if (s_tvalid && s_tready) begin
                power_queue.push_back(predict_powers(s_tdata[9:0], s_tdata[19:10], s_tuser[0]));
            end
            if (m_tvalid && m_tready) begin
                if (power_queue.size() == 0) begin
                    report_fault($sformatf("result word 0x%08h with nothing expected", m_tdata));
                end else begin
                    want = power_queue.pop_front();
                    if (m_tdata[12:0] !== want.right_power) begin
                        report_fault($sformatf("right_power %0d, expected %0d",
                                               m_tdata[12:0], want.right_power));
                    end
                    if (m_tdata[25:13] !== want.left_power) begin
                        report_fault($sformatf("left_power %0d, expected %0d",
                                               m_tdata[25:13], want.left_power));
                    end
                    if (m_tuser[0] !== want.range_fault) begin
                        report_fault($sformatf("range_fault %b, expected %b",
                                               m_tuser[0], want.range_fault));
                    end
                    if (m_tdata[31:26] !== 6'd0) begin
                        report_fault($sformatf("padding bits 0x%02h, expected zero",
                                               m_tdata[31:26]));
                    end
                end
            end
            outstanding <= power_queue.size();
        end
    end

endmodule

// ===== tb/sv/dual_sensor_pd_line_follower_core_tb.sv =====
// Testbench top for the line follower core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module dual_sensor_pd_line_follower_core_tb;

    import dspd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 2500;
    localparam int TAIL_CYCLES     = 200;
    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 112;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [9:0] light_raw, [19:10] color_level, rest zero
    logic [0:0]  s_tuser   = '0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [12:0] right_power, [25:13] left_power, rest zero
    logic [0:0]  m_tuser;          // [0] range_fault
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    int error_count;
    int outstanding;

    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    bit hold_request = 1'b0;

    logic [9:0] cur_light = '0;
    logic [9:0] cur_color = '0;

    dual_sensor_pd_line_follower_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dual_sensor_pd_line_follower_core_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random ready bursts, one long hold-off on request.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Offers one sensor word, sometimes after an idle burst, and returns at its acceptance.
    task automatic push_reading(input logic [9:0] light_raw, input logic [9:0] color_level,
                                input logic restart);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, color_level, light_raw};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every predicted word has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all eight registers back to back; valid stays high across the batch.
    task automatic apply_settings(input logic [9:0] p_low, input logic [9:0] p_high,
                                  input logic [9:0] d, input logic [9:0] base,
                                  input logic [9:0] l_lo, input logic [9:0] l_hi,
                                  input logic [9:0] c_lo, input logic [9:0] c_hi);
        write_reg(CFG_GAIN_P_LOW, p_low);
        write_reg(CFG_GAIN_P_HIGH, p_high);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_BASE_POWER, base);
        write_reg(CFG_LIGHT_CAL_LOW, l_lo);
        write_reg(CFG_LIGHT_CAL_HIGH, l_hi);
        write_reg(CFG_COLOR_CAL_LOW, c_lo);
        write_reg(CFG_COLOR_CAL_HIGH, c_hi);
        cfg_valid <= 1'b0;
    endtask

    // Calibration bounds: mostly ordered, sometimes equal or inverted.
    task automatic pick_bounds(output logic [9:0] lo, output logic [9:0] hi);
        int kind;
        int l;
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
            lo = 10'($urandom_range(0, 1023));
            hi = lo;
        end else if (kind == 1) begin
            lo = 10'($urandom_range(512, 1023));
            hi = 10'($urandom_range(0, 511));
        end else begin
            l  = $urandom_range(0, 500);
            lo = 10'(l);
            hi = 10'($urandom_range(l + 1, 1023));
        end
    endtask

    task automatic random_settings(input int style);
        logic [9:0] l_lo, l_hi, c_lo, c_hi;
        logic [9:0] base;
        pick_bounds(l_lo, l_hi);
        pick_bounds(c_lo, c_hi);
        if (style == 0) begin
            apply_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'd100, 10'd0, 10'd1023, 10'd0, 10'd1023);
        end else if (style == 1) begin
            apply_settings(10'd0, 10'd0, 10'd0, 10'd0, l_lo, l_hi, c_lo, c_hi);
        end else if (style == 2) begin
            apply_settings(10'd2, 10'd5, 10'd3, 10'd50, 10'd0, 10'd1023, 10'd0, 10'd1023);
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                base = 10'($urandom_range(0, 1023));
            end else begin
                base = 10'($urandom_range(0, 100));
            end
            apply_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           10'($urandom_range(0, 1023)), base, l_lo, l_hi, c_lo, c_hi);
        end
    endtask

    function automatic logic [9:0] nudge(input logic [9:0] v);
        int n;
        n = int'(v) + int'($urandom_range(0, 120)) - 60;
        if (n < 0) begin
            n = 0;
        end
        if (n > 1023) begin
            n = 1023;
        end
        return n[9:0];
    endfunction

    // Mostly smooth sensor tracks around the straight band, with jumps and restarts mixed in.
    task automatic random_readings(input int count);
        int   k;
        logic restart;
        for (k = 0; k < count; k++) begin
            restart = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 9) == 0) begin
                cur_light = 10'($urandom_range(0, 1023));
                cur_color = 10'($urandom_range(0, 1023));
            end else begin
                cur_light = nudge(cur_light);
                cur_color = nudge(cur_color);
            end
            push_reading(cur_light, cur_color, restart);
        end
    endtask

    initial begin : stimulus
        int phase;
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // Reset settings: full-scale swings, the negative turn clamp and both sides of the band.
        push_reading(10'd0, 10'd0, 1'b0);
        push_reading(10'd1023, 10'd1023, 1'b0);
        push_reading(10'd1023, 10'd0, 1'b1);
        push_reading(10'd512, 10'd511, 1'b0);
        push_reading(10'd463, 10'd560, 1'b0);
        push_reading(10'd513, 10'd610, 1'b0);

        // Collapsed calibration ranges: zero span on both channels, then on light alone.
        wait_idle();
        apply_settings(10'h3FF, 10'd0, 10'h3FF, 10'h3FF, 10'd500, 10'd500, 10'd300, 10'd300);
        push_reading(10'd523, 10'd300, 1'b1);
        push_reading(10'd523, 10'd0, 1'b1);
        push_reading(10'd0, 10'd1023, 1'b0);
        push_reading(10'd1023, 10'd512, 1'b0);

        // Inverted calibration: negative spans, saturated power and a zero span after restart.
        wait_idle();
        apply_settings(10'd0, 10'd42, 10'd63, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0);
        push_reading(10'd23, 10'd1000, 1'b1);
        push_reading(10'd1022, 10'd1, 1'b0);
        push_reading(10'd1000, 10'd20, 1'b0);
        push_reading(10'd0, 10'd1023, 1'b1);

        // Random phases under varied settings; the last one runs without idling.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == PHASES - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            random_settings(phase);
            if (phase == 3) begin
                hold_request = 1'b1;
            end
            random_readings(WORDS_PER_PHASE);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== dual_sensor_pd_line_follower_core.f =====
+incdir+rtl
rtl/dspd_pkg.sv
rtl/dspd_div.sv
rtl/dual_sensor_pd_line_follower_core.sv
rtl/dspd_checker.sv
tb/sv/dual_sensor_pd_line_follower_core_check.sv
tb/sv/dual_sensor_pd_line_follower_core_tb.sv
